// ----- design/pcq_pkg.sv -----
`timescale 1ns / 1ps
// pcq_pkg: shared widths, codes, reset values and payload structs
// for the pose consistency qualifier; no dependencies
package pcq_pkg;

  // fixed-point widths
  localparam int POS_BITS   = 24;
  localparam int COUNT_BITS = 8;
  localparam int HEAD_W     = 16;
  localparam int TIME_W     = 32;

  // configuration register widths
  localparam int REQ_W    = 8;
  localparam int SEP_W    = 24;
  localparam int SEP_SQ_W = 2 * SEP_W;
  localparam int HSEP_W   = 16;
  localparam int WIN_W    = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  // result widths
  localparam int STATUS_W = 3;
  localparam int RUN_W    = 8;

  // derived widths
  localparam int DIFF_W    = POS_BITS + 1;
  localparam int MAG_CMP_W = (DIFF_W > SEP_W) ? DIFF_W : SEP_W;
  localparam int CNT_CMP_W = (COUNT_BITS > REQ_W) ? COUNT_BITS : REQ_W;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // configuration reset values
  localparam logic [REQ_W-1:0]    REQUIRED_RST = REQ_W'(3);
  localparam logic [SEP_W-1:0]    POS_SEP_RST  = SEP_W'(512);
  localparam logic [SEP_SQ_W-1:0] POS_SQ_RST   = SEP_SQ_W'(512 * 512);
  localparam logic [HSEP_W-1:0]   HEAD_SEP_RST = HSEP_W'(910);
  localparam logic [WIN_W-1:0]    WINDOW_RST   = WIN_W'(500);

  // policy limits
  localparam logic [REQ_W-1:0] REQUIRED_MIN = REQ_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REQUIRED_COUNT = 2'd0,
    CFG_MAX_POS_SEP    = 2'd1,
    CFG_MAX_HEAD_SEP   = 2'd2,
    CFG_WINDOW_MS      = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    KIND_OBSERVE = 1'b0,
    KIND_CLEAR   = 1'b1
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INVALID      = 3'd0,
    ST_OUT_OF_ORDER = 3'd1,
    ST_COLLECTING   = 3'd2,
    ST_CONSISTENT   = 3'd3,
    ST_CLEARED      = 3'd4
  } status_e;

  typedef struct packed {
    logic [REQ_W-1:0]    required_count;
    logic [SEP_W-1:0]    max_pos_sep;
    logic [SEP_SQ_W-1:0] pos_sep_sq;
    logic [HSEP_W-1:0]   max_head_sep;
    logic [WIN_W-1:0]    window_ms;
  } cfg_t;

  typedef struct packed {
    kind_e                      kind;
    logic signed [POS_BITS-1:0] x;
    logic signed [POS_BITS-1:0] y;
    logic signed [HEAD_W-1:0]   heading;
    logic [TIME_W-1:0]          stamp;
  } item_t;

  typedef struct packed {
    status_e          status;
    logic             allow;
    logic [RUN_W-1:0] run_count;
  } result_t;

endpackage

// ----- design/pose_consistency_qualifier.sv -----
`timescale 1ns / 1ps
// pose_consistency_qualifier: top level; input register, judge, result register
// depends on pcq_pkg, pcq_cfg_regs, pcq_judge, pcq_out_reg
//
// Qualifies pose candidates (x, y in signed 1/256 inch, binary-angle heading,
// wrapping millisecond timestamp) before relocalization recovery is allowed.
// A request sits in the input register, where the judge compares it against
// the stored reference and updates the run count; its verdict then waits in the
// result register until the sink takes it. A new request is accepted every cycle
// unless the input stalls; each request updates the run count as it advances,
// so back-to-back requests see each other's state. The input stalls only when
// both the input and result registers are full and the sink is stalling. Policy
// registers are written through the plain write port; the user must do so only
// while no request is in flight, which the block does not enforce. The squared
// position radius is formed at write time. A clear request returns the monitor
// to its reset state without touching the policy.

module pose_consistency_qualifier (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write port
  input  logic                                  cfg_we_i,
  input  logic [pcq_pkg::CFG_IDX_W-1:0]         cfg_addr_i,
  input  logic [pcq_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  // candidate requests
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  in_kind_i,
  input  logic signed [pcq_pkg::POS_BITS-1:0]   in_cand_x_i,
  input  logic signed [pcq_pkg::POS_BITS-1:0]   in_cand_y_i,
  input  logic signed [pcq_pkg::HEAD_W-1:0]     in_cand_heading_i,
  input  logic [pcq_pkg::TIME_W-1:0]            in_cand_time_i,
  // results
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [pcq_pkg::STATUS_W-1:0]          out_status_o,
  output logic                                  out_allow_o,
  output logic [pcq_pkg::RUN_W-1:0]             out_run_count_o
);

  pcq_pkg::cfg_t    cfg;
  pcq_pkg::item_t   item_q;
  pcq_pkg::result_t judge_res;
  pcq_pkg::result_t out_res;
  logic             in_valid_q, in_valid_d;
  logic             out_ready;
  logic             advance;
  logic             accept;

  // policy registers
  pcq_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // input register: it moves on whenever the result register can take it
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.kind    <= pcq_pkg::kind_e'(in_kind_i);
      item_q.x       <= in_cand_x_i;
      item_q.y       <= in_cand_y_i;
      item_q.heading <= in_cand_heading_i;
      item_q.stamp   <= in_cand_time_i;
    end
  end

  // agreement check and monitor state, committed as the request advances
  pcq_judge u_judge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .update_i (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (judge_res)
  );

  // result register toward the sink
  pcq_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (in_valid_q),
    .load_data_i  (judge_res),
    .ready_o      (out_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_res)
  );

  assign out_status_o    = out_res.status;
  assign out_allow_o     = out_res.allow;
  assign out_run_count_o = out_res.run_count;

  // allow goes with the consistent status and nothing else
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_allow_o == (out_status_o == pcq_pkg::ST_CONSISTENT)))
    else $error("allow does not match consistent status");

  // a cleared result reports an empty run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_status_o == pcq_pkg::ST_CLEARED)) |-> (out_run_count_o == '0))
    else $error("cleared result with nonzero run count");

  // input never stalls while the input register is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !in_stall_o)
    else $error("input stalled with empty input register");

  // a request held in the input register moves on when the result register is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_valid_o) |=> (out_valid_o))
    else $error("request did not reach the result register");

endmodule

// ----- design/pcq_cfg_regs.sv -----
`timescale 1ns / 1ps
// pcq_cfg_regs: policy registers of the qualifier, with the squared
// position radius kept alongside; depends on pcq_pkg
module pcq_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pcq_pkg::CFG_IDX_W-1:0]       cfg_addr_i,
  input  logic [pcq_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  output pcq_pkg::cfg_t                       cfg_o
);

  pcq_pkg::cfg_t cfg_q, cfg_d;
  logic [pcq_pkg::SEP_W-1:0] sep_new;

  assign sep_new = cfg_wdata_i[pcq_pkg::SEP_W-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (pcq_pkg::cfg_idx_e'(cfg_addr_i))
        pcq_pkg::CFG_REQUIRED_COUNT: begin
          cfg_d.required_count = cfg_wdata_i[pcq_pkg::REQ_W-1:0];
        end
        pcq_pkg::CFG_MAX_POS_SEP: begin
          cfg_d.max_pos_sep = sep_new;
          // radius squared, ready for the distance compare
          cfg_d.pos_sep_sq  = pcq_pkg::SEP_SQ_W'(sep_new) * pcq_pkg::SEP_SQ_W'(sep_new);
        end
        pcq_pkg::CFG_MAX_HEAD_SEP: begin
          cfg_d.max_head_sep = cfg_wdata_i[pcq_pkg::HSEP_W-1:0];
        end
        pcq_pkg::CFG_WINDOW_MS: begin
          cfg_d.window_ms = cfg_wdata_i[pcq_pkg::WIN_W-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.required_count <= pcq_pkg::REQUIRED_RST;
      cfg_q.max_pos_sep    <= pcq_pkg::POS_SEP_RST;
      cfg_q.pos_sep_sq     <= pcq_pkg::POS_SQ_RST;
      cfg_q.max_head_sep   <= pcq_pkg::HEAD_SEP_RST;
      cfg_q.window_ms      <= pcq_pkg::WINDOW_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/pcq_judge.sv -----
`timescale 1ns / 1ps
// pcq_judge: reference pose and run count, and the single-pass agreement
// check of one registered request; depends on pcq_pkg
module pcq_judge (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             update_i,
  input  pcq_pkg::item_t   item_i,
  input  pcq_pkg::cfg_t    cfg_i,
  output pcq_pkg::result_t result_o
);

  localparam int DW = pcq_pkg::DIFF_W;
  localparam int MW = pcq_pkg::MAG_CMP_W;
  localparam int SW = pcq_pkg::SEP_W;
  localparam int QW = pcq_pkg::SEP_SQ_W;
  localparam int CW = pcq_pkg::CNT_CMP_W;

  // reference and run state
  logic signed [pcq_pkg::POS_BITS-1:0] ref_x_q, ref_y_q;
  logic signed [pcq_pkg::HEAD_W-1:0]   ref_head_q;
  logic [pcq_pkg::TIME_W-1:0]          ref_time_q;
  logic [pcq_pkg::COUNT_BITS-1:0]      count_q, count_d;
  logic                                has_ref_q, has_ref_d;
  logic                                load_ref;

  logic                       policy_bad;
  logic [pcq_pkg::TIME_W-1:0] dt;
  logic                       out_of_order;
  logic signed [DW-1:0]       dx, dy;
  logic [DW-1:0]              ax, ay;
  logic                       box_ok;
  logic [QW-1:0]              sq_x, sq_y;
  logic [QW:0]                dist_sq;
  logic                       pos_ok;
  logic [pcq_pkg::HEAD_W-1:0] dh;
  logic [pcq_pkg::HEAD_W:0]   hmag;
  logic                       head_ok, time_ok, agrees;
  logic [pcq_pkg::COUNT_BITS-1:0] count_inc;
  pcq_pkg::result_t           res;

  assign policy_bad = (cfg_i.required_count < pcq_pkg::REQUIRED_MIN) ||
                      (cfg_i.window_ms == '0);

  // wrapped elapsed time; later means nonzero and in the lower half
  assign dt           = item_i.stamp - ref_time_q;
  assign out_of_order = has_ref_q && ((dt == '0) || dt[pcq_pkg::TIME_W-1]);

  // position separation, magnitudes first then squares
  assign dx = DW'(item_i.x) - DW'(ref_x_q);
  assign dy = DW'(item_i.y) - DW'(ref_y_q);
  assign ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign ay = dy[DW-1] ? DW'(-dy) : DW'(dy);

  assign box_ok = (MW'(ax) <= MW'(cfg_i.max_pos_sep)) &&
                  (MW'(ay) <= MW'(cfg_i.max_pos_sep));

  // inside the box both magnitudes fit the radius width
  assign sq_x    = QW'(SW'(ax)) * QW'(SW'(ax));
  assign sq_y    = QW'(SW'(ay)) * QW'(SW'(ay));
  assign dist_sq = (QW+1)'(sq_x) + (QW+1)'(sq_y);
  assign pos_ok  = box_ok && (dist_sq <= (QW+1)'(cfg_i.pos_sep_sq));

  // wrapped heading difference, half turn counts as full magnitude
  assign dh   = item_i.heading - ref_head_q;
  assign hmag = dh[pcq_pkg::HEAD_W-1] ? ((pcq_pkg::HEAD_W+1)'(1) << pcq_pkg::HEAD_W) -
                                        (pcq_pkg::HEAD_W+1)'(dh)
                                      : (pcq_pkg::HEAD_W+1)'(dh);
  assign head_ok = hmag <= (pcq_pkg::HEAD_W+1)'(cfg_i.max_head_sep);
  assign time_ok = dt <= cfg_i.window_ms;

  assign agrees = pos_ok && head_ok && time_ok;

  assign count_inc = (count_q == pcq_pkg::COUNT_MAX) ? count_q : count_q + 1'b1;

  always_comb begin
    count_d        = count_q;
    has_ref_d      = has_ref_q;
    load_ref       = 1'b0;
    res.status     = pcq_pkg::ST_COLLECTING;
    res.allow      = 1'b0;
    res.run_count  = pcq_pkg::RUN_W'(count_q);
    if (item_i.kind == pcq_pkg::KIND_CLEAR) begin
      count_d       = '0;
      has_ref_d     = 1'b0;
      res.status    = pcq_pkg::ST_CLEARED;
      res.run_count = '0;
    end else if (policy_bad) begin
      res.status = pcq_pkg::ST_INVALID;
    end else if (out_of_order) begin
      res.status = pcq_pkg::ST_OUT_OF_ORDER;
    end else if (!has_ref_q) begin
      // first candidate becomes the reference
      load_ref      = 1'b1;
      has_ref_d     = 1'b1;
      count_d       = pcq_pkg::COUNT_BITS'(1);
      res.run_count = pcq_pkg::RUN_W'(1);
    end else if (!agrees) begin
      load_ref      = 1'b1;
      count_d       = pcq_pkg::COUNT_BITS'(1);
      res.run_count = pcq_pkg::RUN_W'(1);
    end else begin
      load_ref      = 1'b1;
      count_d       = count_inc;
      res.run_count = pcq_pkg::RUN_W'(count_inc);
      if (CW'(count_inc) >= CW'(cfg_i.required_count)) begin
        res.status = pcq_pkg::ST_CONSISTENT;
        res.allow  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      has_ref_q <= 1'b0;
    end else if (update_i) begin
      count_q   <= count_d;
      has_ref_q <= has_ref_d;
    end
  end

  // reference values are only read while has_ref_q is set
  always_ff @(posedge clk_i) begin
    if (update_i && load_ref) begin
      ref_x_q    <= item_i.x;
      ref_y_q    <= item_i.y;
      ref_head_q <= item_i.heading;
      ref_time_q <= item_i.stamp;
    end
  end

  assign result_o = res;

endmodule

// ----- design/pcq_out_reg.sv -----
`timescale 1ns / 1ps
// pcq_out_reg: result register with valid/stall handshake toward the sink
// depends on pcq_pkg
module pcq_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_valid_i,
  input  pcq_pkg::result_t load_data_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pcq_pkg::result_t out_data_o
);

  logic             valid_q, valid_d;
  pcq_pkg::result_t data_q;
  logic             load;

  // the register frees up in the same cycle its request is taken
  assign ready_o = !valid_q || !out_stall_i;
  assign load    = load_valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= load_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ----- bench/tb_pose_consistency_qualifier.sv -----
`timescale 1ns / 1ps
// tb_pose_consistency_qualifier: self-checking bench for the pose consistency qualifier
// depends on pcq_pkg and pose_consistency_qualifier; needs no files or arguments

module tb_pose_consistency_qualifier;
  import pcq_pkg::*;

  localparam int QUIET_LIMIT = 2000;  // cycles with nothing moving before giving up
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE_CYCLES = 4;   // two-register pipe plus margin

  // dut ports, inputs all driven to known values from time zero
  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic                       in_kind_i = 1'b0;
  logic signed [POS_BITS-1:0] in_cand_x_i = '0;
  logic signed [POS_BITS-1:0] in_cand_y_i = '0;
  logic signed [HEAD_W-1:0]   in_cand_heading_i = '0;
  logic [TIME_W-1:0]          in_cand_time_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [STATUS_W-1:0]        out_status_o;
  logic                       out_allow_o;
  logic [RUN_W-1:0]           out_run_count_o;

  // policy mirror, tracks every register write
  logic [REQ_W-1:0]  pol_required = REQUIRED_RST;
  logic [SEP_W-1:0]  pol_pos_sep  = POS_SEP_RST;
  logic [HSEP_W-1:0] pol_head_sep = HEAD_SEP_RST;
  logic [WIN_W-1:0]  pol_window   = WINDOW_RST;

  // monitor mirror: last reference pose and run length
  logic signed [POS_BITS-1:0] anchor_x = '0;
  logic signed [POS_BITS-1:0] anchor_y = '0;
  logic [HEAD_W-1:0]          anchor_heading = '0;
  logic [TIME_W-1:0]          anchor_time = '0;
  logic [COUNT_BITS-1:0]      run_len = '0;
  logic                       anchored = 1'b0;

  // verdicts predicted for accepted requests, oldest first
  result_t expected_results[$];
  result_t pending;

  // pose walk used by the random phases
  int                trk_x, trk_y, trk_h;
  logic [TIME_W-1:0] trk_t;

  // idling knobs
  int gap_max = 0;
  int burst_left = 8;
  int stall_pct = 0;

  int requests_sent = 0;
  int results_seen = 0;
  int allowed_seen = 0;
  int late_seen = 0;
  int cleared_seen = 0;
  int cfg_writes = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  pose_consistency_qualifier dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // next verdict of the monitor for one request; updates the mirror state
  function automatic result_t qualify_pose(kind_e kind, logic signed [POS_BITS-1:0] x,
                                           logic signed [POS_BITS-1:0] y,
                                           logic [HEAD_W-1:0] heading,
                                           logic [TIME_W-1:0] stamp);
    result_t           res;
    logic [TIME_W-1:0] elapsed;
    logic [HEAD_W-1:0] turn;
    longint            ax, ay, radius, turn_mag;
    bit                agrees;
    res.status    = ST_COLLECTING;
    res.allow     = 1'b0;
    res.run_count = RUN_W'(run_len);
    if (kind == KIND_CLEAR) begin
      anchor_x       = '0;
      anchor_y       = '0;
      anchor_heading = '0;
      anchor_time    = '0;
      run_len        = '0;
      anchored       = 1'b0;
      res.status     = ST_CLEARED;
      res.run_count  = '0;
      return res;
    end
    // policy check comes before anything touches the state
    if (pol_required < REQUIRED_MIN || pol_window == '0) begin
      res.status = ST_INVALID;
      return res;
    end
    // stamp must be strictly later, within half the counter range
    elapsed = stamp - anchor_time;
    if (anchored && (elapsed == '0 || elapsed[TIME_W-1])) begin
      res.status = ST_OUT_OF_ORDER;
      return res;
    end
    if (!anchored) begin
      agrees = 1'b0;
    end else begin
      ax = longint'(x) - longint'(anchor_x);
      ay = longint'(y) - longint'(anchor_y);
      if (ax < 0) ax = -ax;
      if (ay < 0) ay = -ay;
      radius = longint'(pol_pos_sep);
      agrees = (ax <= radius) && (ay <= radius) && (ax * ax + ay * ay <= radius * radius);
      // wrapped heading difference, half turn counts as the full 32768
      turn = heading - anchor_heading;
      turn_mag = turn[HEAD_W-1] ? (longint'(1) << HEAD_W) - longint'(turn) : longint'(turn);
      if (turn_mag > longint'(pol_head_sep)) agrees = 1'b0;
      if (elapsed > pol_window) agrees = 1'b0;
    end
    anchor_x       = x;
    anchor_y       = y;
    anchor_heading = heading;
    anchor_time    = stamp;
    anchored       = 1'b1;
    if (!agrees) begin
      run_len = COUNT_BITS'(1);
    end else begin
      if (run_len != COUNT_MAX) run_len = run_len + 1'b1;
      if (run_len >= pol_required) begin
        res.status = ST_CONSISTENT;
        res.allow  = 1'b1;
      end
    end
    res.run_count = RUN_W'(run_len);
    return res;
  endfunction

  function automatic int wobble(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic log_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  // one request through the handshake, then the burst/gap pacing
  task automatic send_pose(kind_e kind, int x, int y, int heading, logic [TIME_W-1:0] stamp);
    int pause;
    in_valid_i        <= 1'b1;
    in_kind_i         <= kind;
    in_cand_x_i       <= POS_BITS'(x);
    in_cand_y_i       <= POS_BITS'(y);
    in_cand_heading_i <= HEAD_W'(heading);
    in_cand_time_i    <= stamp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_results.push_back(qualify_pose(kind, POS_BITS'(x), POS_BITS'(y),
                                            HEAD_W'(heading), stamp));
    requests_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      if (gap_max > 0) begin
        pause = $urandom_range(1, gap_max);
        in_valid_i <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
    end
  endtask

  // hold the sender until every verdict is back, then let the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_REQUIRED_COUNT: pol_required = value[REQ_W-1:0];
      CFG_MAX_POS_SEP:    pol_pos_sep  = value[SEP_W-1:0];
      CFG_MAX_HEAD_SEP:   pol_head_sep = value[HSEP_W-1:0];
      CFG_WINDOW_MS:      pol_window   = value[WIN_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // policy only changes with the pipe empty
  task automatic set_policy(int required, int pos_sep, int head_sep, logic [WIN_W-1:0] window);
    drain();
    write_reg(CFG_REQUIRED_COUNT, CFG_DATA_W'(required));
    write_reg(CFG_MAX_POS_SEP, CFG_DATA_W'(pos_sep));
    write_reg(CFG_MAX_HEAD_SEP, CFG_DATA_W'(head_sep));
    write_reg(CFG_WINDOW_MS, window);
  endtask

  // mostly in-tolerance walks, some boundary steps, jumps, late stamps and clears
  task automatic run_tracking(int count, int clear_pct, int late_pct, int jump_pct);
    int                roll, near_pos, wide_pos, near_head, wide_head;
    longint            near_gap, wide_gap;
    logic [TIME_W-1:0] late;
    near_pos  = int'(pol_pos_sep) * 7 / 10;
    wide_pos  = int'(pol_pos_sep) + int'(pol_pos_sep) / 8 + 1;
    near_head = int'(pol_head_sep) * 7 / 10;
    wide_head = int'(pol_head_sep) + int'(pol_head_sep) / 8 + 1;
    near_gap  = longint'(pol_window) * 7 / 10;
    wide_gap  = longint'(pol_window) + longint'(pol_window) / 8 + 1;
    if (near_gap < 1) near_gap = 1;
    if (near_gap > 32'h7FFF_FFFF) near_gap = 32'h7FFF_FFFF;
    if (wide_gap > 32'h7FFF_FFFF) wide_gap = 32'h7FFF_FFFF;
    // start the walk from the current reference
    trk_x = anchor_x;
    trk_y = anchor_y;
    trk_h = anchor_heading;
    trk_t = anchor_time;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < clear_pct) begin
        send_pose(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom);
      end else if (roll < clear_pct + late_pct) begin
        if ($urandom_range(0, 1)) late = trk_t - $urandom_range(0, 3);
        else late = trk_t + 32'h8000_0000 + $urandom_range(0, 4095);
        send_pose(KIND_OBSERVE, trk_x, trk_y, trk_h, late);
      end else begin
        if (roll < clear_pct + late_pct + jump_pct) begin
          trk_x = $urandom;
          trk_y = $urandom;
          trk_h = $urandom;
          trk_t = trk_t + $urandom_range(1, 32'(wide_gap));
        end else if ($urandom_range(0, 3) != 0) begin
          trk_x += wobble(near_pos);
          trk_y += wobble(near_pos);
          trk_h += wobble(near_head);
          trk_t = trk_t + $urandom_range(1, 32'(near_gap));
        end else begin
          trk_x += wobble(wide_pos);
          trk_y += wobble(wide_pos);
          trk_h += wobble(wide_head);
          trk_t = trk_t + $urandom_range(1, 32'(wide_gap));
        end
        send_pose(KIND_OBSERVE, trk_x, trk_y, trk_h, trk_t);
      end
    end
  endtask

  // reset policy: radius, diagonal, heading, window, stamp order and wrap edges
  task automatic test_directed_tracking();
    gap_max   = 0;
    stall_pct = 0;
    send_pose(KIND_CLEAR, 0, 0, 0, 0);
    send_pose(KIND_OBSERVE, 0, 0, 0, 1000);        // first candidate becomes reference
    send_pose(KIND_OBSERVE, 100, -100, 200, 1100);
    send_pose(KIND_OBSERVE, 612, -100, 200, 1600); // dx on the radius, gap on the window
    send_pose(KIND_OBSERVE, 612, -100, 200, 1600); // repeated stamp
    send_pose(KIND_OBSERVE, 612, -100, 200, 1500); // stamp going backwards
    send_pose(KIND_OBSERVE, 612, -100, 200, 32'd1600 + 32'h8000_0000); // half range ahead
    send_pose(KIND_OBSERVE, 1125, -100, 200, 1700); // one past the radius on x
    send_pose(KIND_OBSERVE, 1488, 263, 200, 1800);  // diagonal just outside the circle
    send_pose(KIND_OBSERVE, 1850, 625, 200, 1900);  // diagonal just inside
    send_pose(KIND_OBSERVE, 1850, 625, 1110, 2000); // heading on the limit
    send_pose(KIND_OBSERVE, 1850, 625, 2021, 2100); // heading one past
    send_pose(KIND_OBSERVE, 1850, 625, 2021, 2601); // gap one past the window
    send_pose(KIND_OBSERVE, 8388607, 8388607, 32767, 2700);
    send_pose(KIND_OBSERVE, -8388608, -8388608, -32768, 2800); // heading wraps by one
    send_pose(KIND_OBSERVE, -8388608, -8388608, 0, 2900);      // exact half turn
    send_pose(KIND_CLEAR, 0, 0, 0, 0);
    send_pose(KIND_OBSERVE, 0, 0, 0, 32'hFFFF_FFFF);           // stamp counter wraps
    send_pose(KIND_OBSERVE, 0, 0, 0, 32'h0000_0000);
    send_pose(KIND_OBSERVE, 0, 0, 0, 32'h0000_0100);
  endtask

  // invalid policies, zero tolerances and fully open tolerances
  task automatic test_policy_limits();
    set_policy(0, 512, 910, 500);
    send_pose(KIND_OBSERVE, 5, 5, 5, 3000);
    set_policy(1, 512, 910, 500);
    send_pose(KIND_OBSERVE, 5, 5, 5, 3000);
    set_policy(2, 512, 910, 0);
    send_pose(KIND_OBSERVE, 5, 5, 5, 3000);
    send_pose(KIND_CLEAR, 0, 0, 0, 0);             // clear ignores a bad policy
    set_policy(2, 0, 0, 1);
    send_pose(KIND_OBSERVE, 7, 7, 7, 5000);
    send_pose(KIND_OBSERVE, 7, 7, 7, 5001);
    send_pose(KIND_OBSERVE, 7, 7, 7, 5003);
    send_pose(KIND_OBSERVE, 8, 7, 7, 5004);
    send_pose(KIND_OBSERVE, 8, 7, 8, 5005);
    set_policy(2, 16777215, 32768, 32'hFFFF_FFFF);
    send_pose(KIND_OBSERVE, -8388608, 8388607, -32768, 6000);
    send_pose(KIND_OBSERVE, 8388607, -8388608, 0, 32'd6000 + 32'h7FFF_FFFF);
  endtask

  task automatic test_default_tracking();
    set_policy(3, 512, 910, 500);
    gap_max   = 6;
    stall_pct = 30;
    run_tracking(120, 4, 8, 10);
  endtask

  // no idling on either side here
  task automatic test_tight_tolerances();
    set_policy(2, 0, 0, 1);
    gap_max   = 0;
    stall_pct = 0;
    run_tracking(80, 3, 8, 8);
  endtask

  // every in-order pose agrees, so the run count climbs to 255 and saturates
  task automatic test_saturating_run();
    set_policy(255, 16777215, 32768, 32'hFFFF_FFFF);
    gap_max   = 3;
    stall_pct = 70;
    send_pose(KIND_CLEAR, 0, 0, 0, 0);
    // small steady steps keep the run unbroken well past the count limit
    for (int n = 0; n < 260; n++) begin
      send_pose(KIND_OBSERVE, n % 5, 0, n % 7, 32'(n + 1));
    end
    run_tracking(40, 0, 2, 0);
  endtask

  // stricter count, with a full pause of the sender midway
  task automatic test_loose_tracking();
    set_policy(5, 4000, 3000, 100000);
    gap_max   = 10;
    stall_pct = 50;
    run_tracking(60, 3, 8, 8);
    drain();
    gap_max   = 2;
    stall_pct = 10;
    run_tracking(60, 3, 8, 8);
  endtask

  // sink stalls at random, rate set per phase
  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (out_status_o == ST_CONSISTENT) allowed_seen++;
      if (out_status_o == ST_OUT_OF_ORDER) late_seen++;
      if (out_status_o == ST_CLEARED) cleared_seen++;
      if (expected_results.size() == 0) begin
        log_mismatch($sformatf("result with nothing pending: status %0d allow %0b run %0d",
                               out_status_o, out_allow_o, out_run_count_o));
      end else begin
        pending = expected_results.pop_front();
        if (out_status_o !== pending.status || out_allow_o !== pending.allow ||
            out_run_count_o !== pending.run_count) begin
          log_mismatch($sformatf("status %0d/%0d allow %0b/%0b run %0d/%0d (want/got)",
                                 pending.status, out_status_o, pending.allow, out_allow_o,
                                 pending.run_count, out_run_count_o));
        end
      end
    end
  end

  // watchdog on cycles where no request and no result moves
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles, %0d verdicts outstanding",
               QUIET_LIMIT, expected_results.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_tracking();
    test_policy_limits();
    test_default_tracking();
    test_tight_tolerances();
    test_saturating_run();
    test_loose_tracking();
    drain();
    $display("%0d requests, %0d results: %0d allowed, %0d out of order, %0d cleared",
             requests_sent, results_seen, allowed_seen, late_seen, cleared_seen);
    $display("%0d policy writes from invalid through zero to fully open tolerances, %0d bad",
             cfg_writes, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
